FILE: src/ipv4_header_check_ttl_update_core_assert.svh
// Assertion macros for the IPv4 header check core.
`ifndef IPV4_HEADER_CHECK_TTL_UPDATE_CORE_ASSERT_SVH
`define IPV4_HEADER_CHECK_TTL_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IHC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipv4 header check: assertion failed");

// Next-cycle implication, disabled during reset.
`define IHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipv4 header check: assertion failed");

`endif

FILE: src/ipv4hc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4hc_pkg;

    localparam int WORD_W    = 16;
    localparam int SUM_W     = 21;
    localparam int VERDICT_W = 3;
    localparam int CMP_W     = 5;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_FORWARD     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_VERSION = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TTL_EXPIRED = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_CSUM    = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_LENGTH  = 3'd4;

    // header word positions
    localparam int IDX_VER_LEN   = 0;
    localparam int IDX_TTL_PROTO = 4;
    localparam int IDX_CSUM      = 5;
    localparam int IDX_DEST_HI   = 8;
    localparam int IDX_DEST_LO   = 9;

    localparam logic [3:0]        IPV4_VERSION = 4'd4;
    localparam logic [3:0]        MIN_IHL      = 4'd5;
    localparam logic [7:0]        TTL_MIN_OK   = 8'd2;
    localparam logic [WORD_W-1:0] CSUM_GOOD    = 16'hffff;

    // header totals handed from the accumulator to the verdict stage
    typedef struct packed {
        logic [7:0]       ver_len;
        logic             short_len;
        logic [7:0]       hop;
        logic [7:0]       proto;
        logic [31:0]      dest;
        logic [SUM_W-1:0] full_sum;
        logic [SUM_W-1:0] send_sum;
    } snap_t;

endpackage

`default_nettype wire

FILE: src/ipv4_header_check_ttl_update_core.sv
`timescale 1ns / 1ps
`default_nettype none

// IPv4 header check and TTL update. Header words stream in on s_ at one word
// per cycle while s_ready is high, with s_last_word on the final word; each word
// within both the IHL length and MAX_HEADER_WORDS is folded into a running
// ones-complement sum in the cycle it is accepted. The final word loads a header
// snapshot register; once the result register is free, the verdict, the
// decremented TTL and the recomputed checksum are registered into it. A new packet may start in
// the cycle right after a last word. The input stalls only while both the
// snapshot and the result register are full and m_ready is low.

`include "ipv4_header_check_ttl_update_core_assert.svh"

module ipv4_header_check_ttl_update_core #(
    parameter int MAX_HEADER_WORDS = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_header_word,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_verdict,
    output logic [7:0]       m_new_ttl,
    output logic [15:0]      m_new_checksum,
    output logic [31:0]      m_dest_address,
    output logic [7:0]       m_protocol_number
);

    localparam int IDX_W = $clog2(MAX_HEADER_WORDS + 1);
    localparam int CMP_W = (IDX_W > ipv4hc_pkg::CMP_W) ? IDX_W : ipv4hc_pkg::CMP_W;
    localparam int SUM_W = ipv4hc_pkg::SUM_W;

    // per-packet accumulator
    logic [IDX_W-1:0] word_index_reg, word_index_next;
    logic [SUM_W-1:0] full_sum_reg, full_sum_next;
    logic [SUM_W-1:0] send_sum_reg, send_sum_next;
    logic [7:0]       ver_len_reg, ver_len_next;
    logic [7:0]       hop_reg, hop_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      dest_reg, dest_next;

    // snapshot and result stages
    ipv4hc_pkg::snap_t snap_reg, snap_next;
    logic              snap_valid_reg;
    logic              out_valid_reg;
    logic [2:0]        verdict_reg, verdict_next;
    logic [7:0]        new_ttl_reg, new_ttl_next;
    logic [15:0]       new_csum_reg, new_csum_next;
    logic [31:0]       out_dest_reg;
    logic [7:0]        out_proto_reg;

    logic             in_accept, accept_last, out_load_ok, snap_move;
    logic             in_range, sum_en;
    logic [CMP_W-1:0] ihl2;
    logic [15:0]      send_word;

    // handshake
    assign out_load_ok = !out_valid_reg || m_ready;
    assign snap_move   = snap_valid_reg && out_load_ok;
    assign s_ready     = !snap_valid_reg || out_load_ok;
    assign in_accept   = s_valid && s_ready;
    assign accept_last = in_accept && s_last_word;

    // fold one word into the running header state
    always_comb begin
        in_range        = word_index_reg < IDX_W'(MAX_HEADER_WORDS);
        ver_len_next    = ver_len_reg;
        hop_next        = hop_reg;
        proto_next      = proto_reg;
        dest_next       = dest_reg;
        send_word       = s_header_word;
        word_index_next = word_index_reg;
        if (in_range) begin
            word_index_next = word_index_reg + IDX_W'(1);
            if (word_index_reg == IDX_W'(ipv4hc_pkg::IDX_VER_LEN)) begin
                ver_len_next = s_header_word[15:8];
            end
            if (word_index_reg == IDX_W'(ipv4hc_pkg::IDX_TTL_PROTO)) begin
                hop_next   = s_header_word[15:8];
                proto_next = s_header_word[7:0];
                send_word  = {s_header_word[15:8] - 8'd1, s_header_word[7:0]};
            end
            if (word_index_reg == IDX_W'(ipv4hc_pkg::IDX_CSUM)) begin
                send_word = 16'h0000;
            end
            if (word_index_reg == IDX_W'(ipv4hc_pkg::IDX_DEST_HI)) begin
                dest_next[31:16] = s_header_word;
            end
            if (word_index_reg == IDX_W'(ipv4hc_pkg::IDX_DEST_LO)) begin
                dest_next[15:0] = s_header_word;
            end
        end
        ihl2          = CMP_W'({ver_len_next[3:0], 1'b0});
        sum_en        = in_range && (CMP_W'(word_index_reg) < ihl2);
        full_sum_next = sum_en ? full_sum_reg + SUM_W'(s_header_word) : full_sum_reg;
        send_sum_next = sum_en ? send_sum_reg + SUM_W'(send_word) : send_sum_reg;

        snap_next.ver_len   = ver_len_next;
        snap_next.short_len = CMP_W'(word_index_next) < ihl2;
        snap_next.hop       = hop_next;
        snap_next.proto     = proto_next;
        snap_next.dest      = dest_next;
        snap_next.full_sum  = full_sum_next;
        snap_next.send_sum  = send_sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || accept_last) begin
            word_index_reg <= '0;
            full_sum_reg   <= '0;
            send_sum_reg   <= '0;
            ver_len_reg    <= '0;
            hop_reg        <= '0;
            proto_reg      <= '0;
            dest_reg       <= '0;
        end else if (in_accept) begin
            word_index_reg <= word_index_next;
            full_sum_reg   <= full_sum_next;
            send_sum_reg   <= send_sum_next;
            ver_len_reg    <= ver_len_next;
            hop_reg        <= hop_next;
            proto_reg      <= proto_next;
            dest_reg       <= dest_next;
        end
    end

    // hold the finished header until the result register frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (accept_last) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_move) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_last) begin
            snap_reg <= snap_next;
        end
    end

    // verdict, carry folds and the new checksum
    logic [16:0] full_f1, send_f1;
    logic [15:0] full_f2, send_f2;

    always_comb begin
        full_f1 = {1'b0, snap_reg.full_sum[15:0]} + 17'(snap_reg.full_sum[SUM_W-1:16]);
        full_f2 = full_f1[15:0] + 16'(full_f1[16]);
        send_f1 = {1'b0, snap_reg.send_sum[15:0]} + 17'(snap_reg.send_sum[SUM_W-1:16]);
        send_f2 = send_f1[15:0] + 16'(send_f1[16]);

        if (snap_reg.ver_len[7:4] != ipv4hc_pkg::IPV4_VERSION) begin
            verdict_next = ipv4hc_pkg::VERDICT_BAD_VERSION;
        end else if (snap_reg.ver_len[3:0] < ipv4hc_pkg::MIN_IHL || snap_reg.short_len) begin
            verdict_next = ipv4hc_pkg::VERDICT_BAD_LENGTH;
        end else if (snap_reg.hop < ipv4hc_pkg::TTL_MIN_OK) begin
            verdict_next = ipv4hc_pkg::VERDICT_TTL_EXPIRED;
        end else if (full_f2 != ipv4hc_pkg::CSUM_GOOD) begin
            verdict_next = ipv4hc_pkg::VERDICT_BAD_CSUM;
        end else begin
            verdict_next = ipv4hc_pkg::VERDICT_FORWARD;
        end
        new_ttl_next  = snap_reg.hop - 8'd1;
        new_csum_next = ~send_f2;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (snap_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_move) begin
            verdict_reg   <= verdict_next;
            new_ttl_reg   <= new_ttl_next;
            new_csum_reg  <= new_csum_next;
            out_dest_reg  <= snap_reg.dest;
            out_proto_reg <= snap_reg.proto;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_verdict         = verdict_reg;
    assign m_new_ttl         = new_ttl_reg;
    assign m_new_checksum    = new_csum_reg;
    assign m_dest_address    = out_dest_reg;
    assign m_protocol_number = out_proto_reg;

    // checks
    `IHC_ASSERT_NEXT(a_last_loads_snap, aclk, aresetn, accept_last, snap_valid_reg)
    `IHC_ASSERT_NEXT(a_last_clears_index, aclk, aresetn, accept_last, word_index_reg == '0)
    `IHC_ASSERT_NOW(a_index_saturates, aclk, aresetn, 1'b1,
        word_index_reg <= IDX_W'(MAX_HEADER_WORDS))
    `IHC_ASSERT_NOW(a_forward_ttl_live, aclk, aresetn,
        m_valid && m_verdict == ipv4hc_pkg::VERDICT_FORWARD,
        m_new_ttl != 8'h00 && m_new_ttl != 8'hff)

endmodule

`default_nettype wire
